@@ src/skvt_pkg.sv @@
// Shared types and constants of the sorted key/value table.
`default_nettype none

package skvt_pkg;

  // Defaults for the top-level parameters.
  localparam int CAPACITY_DEFAULT   = 16;
  localparam int KEY_BITS_DEFAULT   = 32;
  localparam int VALUE_BITS_DEFAULT = 32;

  // Fixed widths of the channel fields.
  localparam int OP_BITS    = 3;
  localparam int FIELD_BITS = 32;
  localparam int INDEX_BITS = 4;
  localparam int COUNT_BITS = 5;

  typedef enum logic [OP_BITS-1:0] {
    OP_INSERT     = 3'd0,
    OP_UPDATE     = 3'd1,
    OP_UPSERT     = 3'd2,
    OP_ERASE      = 3'd3,
    OP_GET_KEY    = 3'd4,
    OP_GET_INDEX  = 3'd5
  } op_t;

  typedef struct packed {
    logic [OP_BITS-1:0]    op;
    logic [FIELD_BITS-1:0] key;
    logic [FIELD_BITS-1:0] value_in;
    logic [INDEX_BITS-1:0] index;
  } cmd_t;

  typedef struct packed {
    logic                  ok;
    logic                  full_res;
    logic [FIELD_BITS-1:0] key_out;
    logic [FIELD_BITS-1:0] value_out;
    logic [COUNT_BITS-1:0] count;
  } res_t;

  // Broadcast to every cell in the cycle an operation is committed.
  typedef struct packed {
    logic do_insert;
    logic do_update;
    logic do_erase;
  } cell_ctrl_t;

endpackage

`default_nettype wire

@@ src/sorted_key_value_table_top.sv @@
// Top level of the sorted key/value table: control, result register and cell chain.
//
//   Channel  Signals                        Direction  Carries
//   cmd      cmd_valid, cmd_stall, cmd      in         one operation (cmd_t)
//   res      res_valid, res_stall, res      out        one result per operation (res_t)
//
// Every operation first captures the command, then executes; in that step every
// cell compares its key with the command key and the whole chain shifts, updates
// or is read at once. A new command is taken in the cycle after commit.
// If the previous result is still stalled at the output, the execute cycle waits
// until it is taken. Reset clears the entry count and the handshake state only;
// the entries need no clearing pass, as cells above the count are never read.
`default_nettype none

module sorted_key_value_table_top #(
  parameter int CAPACITY   = skvt_pkg::CAPACITY_DEFAULT,
  parameter int KEY_BITS   = skvt_pkg::KEY_BITS_DEFAULT,
  parameter int VALUE_BITS = skvt_pkg::VALUE_BITS_DEFAULT
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           cmd_valid,
  output logic                cmd_stall,
  input  wire skvt_pkg::cmd_t cmd,
  output logic                res_valid,
  input  wire logic           res_stall,
  output skvt_pkg::res_t      res
);

  localparam int CNT_BITS = $clog2(CAPACITY + 1);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EXEC = 2'b10
  } state_t;

  state_t state, state_next;

  // Captured command, reduced to the stored widths.
  logic [skvt_pkg::OP_BITS-1:0]    op_r;
  logic [KEY_BITS-1:0]             key_r;
  logic [VALUE_BITS-1:0]           value_r;
  logic [skvt_pkg::INDEX_BITS-1:0] index_r;

  logic [CNT_BITS-1:0] entry_count, entry_count_next;

  logic [63:0] cmd_key_wide, cmd_value_wide;

  // Cell chain wiring.
  logic [KEY_BITS-1:0]   cell_key   [CAPACITY];
  logic [VALUE_BITS-1:0] cell_value [CAPACITY];
  logic [CAPACITY-1:0]   lt_vec, hit_vec, sel_vec;

  skvt_pkg::cell_ctrl_t ctrl, ctrl_gated;

  logic                  commit;
  logic                  any_hit, any_sel, table_full;
  logic [KEY_BITS-1:0]   hit_key, sel_key;
  logic [VALUE_BITS-1:0] hit_value, sel_value;

  logic                  ok, full_flag;
  logic [KEY_BITS-1:0]   key_found;
  logic [VALUE_BITS-1:0] value_found;
  logic [63:0]           key_found_wide, value_found_wide, count_wide;

  // A command is only taken while no operation is in flight.
  assign cmd_stall = (state != ST_IDLE);

  // The execute cycle commits once the result register is free or being emptied.
  assign commit = (state == ST_EXEC) && (!res_valid || !res_stall);

  assign cmd_key_wide   = 64'(cmd.key);
  assign cmd_value_wide = 64'(cmd.value_in);

  always_ff @(posedge clk) begin
    if (cmd_valid && !cmd_stall) begin
      op_r    <= cmd.op;
      key_r   <= cmd_key_wide[KEY_BITS-1:0];
      value_r <= cmd_value_wide[VALUE_BITS-1:0];
      index_r <= cmd.index;
    end
  end

  // The row of cells; each neighbour pair exchanges its entry and compare flag.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [KEY_BITS-1:0]   left_key, right_key;
    logic [VALUE_BITS-1:0] left_value, right_value;
    logic                  left_lt;

    if (i == 0) begin : g_first
      assign left_key   = '0;
      assign left_value = '0;
      assign left_lt    = 1'b1;
    end else begin : g_inner_left
      assign left_key   = cell_key[i-1];
      assign left_value = cell_value[i-1];
      assign left_lt    = lt_vec[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign right_key   = '0;
      assign right_value = '0;
    end else begin : g_inner_right
      assign right_key   = cell_key[i+1];
      assign right_value = cell_value[i+1];
    end

    skvt_cell #(
      .KEY_BITS   (KEY_BITS),
      .VALUE_BITS (VALUE_BITS),
      .CNT_BITS   (CNT_BITS),
      .POS        (i)
    ) u_cell (
      .clk         (clk),
      .ctrl        (ctrl_gated),
      .entry_count (entry_count),
      .k           (key_r),
      .v           (value_r),
      .index       (index_r),
      .left_key    (left_key),
      .left_value  (left_value),
      .left_lt     (left_lt),
      .right_key   (right_key),
      .right_value (right_value),
      .key         (cell_key[i]),
      .value       (cell_value[i]),
      .lt          (lt_vec[i]),
      .hit         (hit_vec[i]),
      .sel         (sel_vec[i])
    );
  end

  // At most one cell matches the key and at most one the index, so the
  // entries can be gathered with a plain AND-OR.
  always_comb begin
    hit_key   = '0;
    hit_value = '0;
    sel_key   = '0;
    sel_value = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      hit_key   = hit_key   | (hit_vec[i] ? cell_key[i]   : '0);
      hit_value = hit_value | (hit_vec[i] ? cell_value[i] : '0);
      sel_key   = sel_key   | (sel_vec[i] ? cell_key[i]   : '0);
      sel_value = sel_value | (sel_vec[i] ? cell_value[i] : '0);
    end
  end

  assign any_hit    = |hit_vec;
  assign any_sel    = |sel_vec;
  assign table_full = (entry_count >= CNT_BITS'(CAPACITY));

  // Operation decode. A refused or unknown operation leaves the table as it is and
  // reports zero key and value; an insert of a present key returns its entry.
  always_comb begin
    ok               = 1'b0;
    full_flag        = 1'b0;
    key_found        = '0;
    value_found      = '0;
    ctrl             = '0;
    entry_count_next = entry_count;
    unique case (op_r)
      skvt_pkg::OP_INSERT, skvt_pkg::OP_UPSERT: begin
        if (any_hit) begin
          key_found = key_r;
          if (op_r == skvt_pkg::OP_UPSERT) begin
            ctrl.do_update = 1'b1;
            ok             = 1'b1;
            value_found    = value_r;
          end else begin
            value_found = hit_value;
          end
        end else if (table_full) begin
          full_flag = 1'b1;
        end else begin
          ctrl.do_insert   = 1'b1;
          ok               = 1'b1;
          key_found        = key_r;
          value_found      = value_r;
          entry_count_next = CNT_BITS'(entry_count + 1'b1);
        end
      end
      skvt_pkg::OP_UPDATE: begin
        if (any_hit) begin
          ctrl.do_update = 1'b1;
          ok             = 1'b1;
          key_found      = key_r;
          value_found    = value_r;
        end
      end
      skvt_pkg::OP_ERASE: begin
        if (any_hit) begin
          ctrl.do_erase    = 1'b1;
          ok               = 1'b1;
          key_found        = key_r;
          value_found      = hit_value;
          entry_count_next = CNT_BITS'(entry_count - 1'b1);
        end
      end
      skvt_pkg::OP_GET_KEY: begin
        if (any_hit) begin
          ok          = 1'b1;
          key_found   = key_r;
          value_found = hit_value;
        end
      end
      skvt_pkg::OP_GET_INDEX: begin
        if (any_sel) begin
          ok          = 1'b1;
          key_found   = sel_key;
          value_found = sel_value;
        end
      end
      default: begin
      end
    endcase
  end

  // Cells only change in the cycle the result is written.
  assign ctrl_gated = commit ? ctrl : '0;

  assign key_found_wide   = 64'(key_found);
  assign value_found_wide = 64'(value_found);
  assign count_wide       = 64'(entry_count_next);

  always_comb begin
    unique case (state)
      ST_IDLE: state_next = (cmd_valid && !cmd_stall) ? ST_EXEC : ST_IDLE;
      ST_EXEC: state_next = commit ? ST_IDLE : ST_EXEC;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      entry_count <= '0;
      res_valid   <= 1'b0;
    end else begin
      state <= state_next;
      if (commit) begin
        entry_count <= entry_count_next;
        res_valid   <= 1'b1;
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end
    end
  end

  // The result register holds its contents while the transfer is stalled.
  always_ff @(posedge clk) begin
    if (commit) begin
      res.ok        <= ok;
      res.full_res  <= full_flag;
      res.key_out   <= key_found_wide[skvt_pkg::FIELD_BITS-1:0];
      res.value_out <= value_found_wide[skvt_pkg::FIELD_BITS-1:0];
      res.count     <= count_wide[skvt_pkg::COUNT_BITS-1:0];
    end
  end

  // The count never passes the capacity.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    entry_count <= CNT_BITS'(CAPACITY))
    else $error("entry count above capacity");

  // Keys are unique, so at most one cell matches.
  a_unique_hit: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EXEC) |-> ($countones(hit_vec) <= 1))
    else $error("more than one cell matches the key");

  // Sorted order: a cell below the key implies its left neighbour is too.
  a_sorted_prefix: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EXEC) |-> (((lt_vec >> 1) & ~lt_vec) == '0))
    else $error("cell chain is out of key order");

  // A refused insert never also reports success.
  a_ok_full_excl: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> !(res.ok && res.full_res))
    else $error("result reports success and full together");

  // A new result only appears after an execute cycle.
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(res_valid) |-> $past(state == ST_EXEC))
    else $error("result appeared without an execute cycle");

endmodule

`default_nettype wire

@@ src/skvt_cell.sv @@
// One cell of the table: holds the entry at a fixed sorted position.
`default_nettype none

module skvt_cell #(
  parameter int KEY_BITS   = skvt_pkg::KEY_BITS_DEFAULT,
  parameter int VALUE_BITS = skvt_pkg::VALUE_BITS_DEFAULT,
  parameter int CNT_BITS   = 5,
  parameter int POS        = 0
) (
  input  wire logic                            clk,
  input  wire skvt_pkg::cell_ctrl_t            ctrl,
  input  wire logic [CNT_BITS-1:0]             entry_count,
  input  wire logic [KEY_BITS-1:0]             k,
  input  wire logic [VALUE_BITS-1:0]           v,
  input  wire logic [skvt_pkg::INDEX_BITS-1:0] index,
  input  wire logic [KEY_BITS-1:0]             left_key,
  input  wire logic [VALUE_BITS-1:0]           left_value,
  input  wire logic                            left_lt,
  input  wire logic [KEY_BITS-1:0]             right_key,
  input  wire logic [VALUE_BITS-1:0]           right_value,
  output logic [KEY_BITS-1:0]                  key,
  output logic [VALUE_BITS-1:0]                value,
  output logic                                 lt,
  output logic                                 hit,
  output logic                                 sel
);

  logic occupied;

  // The cell holds a live entry when its position is below the entry count.
  assign occupied = int'(entry_count) > POS;
  assign lt       = occupied && (key < k);
  assign hit      = occupied && (key == k);
  assign sel      = occupied && (int'(index) == POS);

  // Keys ascend along the chain, so the cells with a smaller key form a prefix.
  // The insertion point is the first cell whose left neighbour is smaller and
  // which is not; every cell after it takes its left neighbour's entry.
  // At most one of the control flags is set, and in most cycles none is.
  always_ff @(posedge clk) begin
    if (ctrl.do_insert) begin
      if (!left_lt) begin
        key   <= left_key;
        value <= left_value;
      end else if (!lt) begin
        key   <= k;
        value <= v;
      end
    end else if (ctrl.do_erase) begin
      if (!lt) begin
        key   <= right_key;
        value <= right_value;
      end
    end else if (ctrl.do_update) begin
      if (hit) begin
        value <= v;
      end
    end
  end

endmodule

`default_nettype wire
